@@ sv/bvp_pkg.sv @@
// Shared constants for the Boris velocity pusher: default widths,
// port widths and configuration register indexes. No dependencies.
package bvp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_BITS_DEF = 32;

  localparam int IO_BITS       = 32;
  localparam int CFG_IDX_BITS  = 8;
  localparam int CFG_DATA_BITS = 32;
  localparam int DT_BITS       = 31;

  localparam logic [CFG_IDX_BITS-1:0] REG_CHARGE_OVER_MASS = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_TIME_STEP        = CFG_IDX_BITS'(1);

  localparam logic signed [IO_BITS-1:0] QM_RESET = IO_BITS'(65536);
  localparam logic [DT_BITS-1:0]        DT_RESET = DT_BITS'(65536);

endpackage

@@ sv/boris_velocity_push.sv @@
// Boris velocity pusher, top level: a fully pipelined fixed-point Boris step
// with a one-bit-per-stage pipelined divider. Depends on bvp_pkg.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid/in_ready, vel_*, efield_*, bfield_* | into block
//   out     | out_valid/out_ready, new_vel_*             | out of block
//   cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data   | into block
//
// One word is accepted every cycle while the output is not stalled and no
// register write is settling; the divider that forms 2/(1+|t|^2) takes one
// stage per quotient bit.
// Reset is synchronous, clears the valid bits, loads the two registers with
// their reset values and holds input off until the settle counter runs out.
// A stall at the output freezes the whole pipeline in place; nothing is lost
// or repeated. After a register write, input is held off
// while the half-step factor k is recomputed.
module boris_velocity_push #(
  parameter int FRAC_BITS = bvp_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = bvp_pkg::WORD_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [bvp_pkg::IO_BITS-1:0]     vel_x,
  input  logic signed [bvp_pkg::IO_BITS-1:0]     vel_y,
  input  logic signed [bvp_pkg::IO_BITS-1:0]     vel_z,
  input  logic signed [bvp_pkg::IO_BITS-1:0]     efield_x,
  input  logic signed [bvp_pkg::IO_BITS-1:0]     efield_y,
  input  logic signed [bvp_pkg::IO_BITS-1:0]     efield_z,
  input  logic signed [bvp_pkg::IO_BITS-1:0]     bfield_x,
  input  logic signed [bvp_pkg::IO_BITS-1:0]     bfield_y,
  input  logic signed [bvp_pkg::IO_BITS-1:0]     bfield_z,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [bvp_pkg::IO_BITS-1:0]     new_vel_x,
  output logic signed [bvp_pkg::IO_BITS-1:0]     new_vel_y,
  output logic signed [bvp_pkg::IO_BITS-1:0]     new_vel_z,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [bvp_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [bvp_pkg::CFG_DATA_BITS-1:0]      cfg_data
);
  import bvp_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int XW = (W > IO_BITS ? W : IO_BITS) + 1;
  // Dividend 2^(2F+1) + den/2 fits in ND bits.
  localparam int NB = (2*F+1 > W-2) ? 2*F+1 : W-2;
  localparam int ND = NB + 2;
  localparam int DV = 8;           // index of the first divider stage
  localparam int PO = DV + ND + 1; // index of the first post-divider stage
  localparam int NS = PO + 8;

  localparam logic signed [XW-1:0] WMAX_X = (XW'(1) << (W-1)) - XW'(1);
  localparam logic signed [XW-1:0] WMIN_X = -WMAX_X - XW'(1);
  localparam logic signed [XW-1:0] OMAX_X = (XW'(1) << (IO_BITS-1)) - XW'(1);
  localparam logic signed [XW-1:0] OMIN_X = -OMAX_X - XW'(1);
  localparam logic [ND-1:0]        NUM    = ND'(1) << (2*F+1);
  localparam logic [ND-1:0]        WMAX_Q = ND'(WMAX_X);

  // Clamp a wide value into the working word.
  function automatic logic signed [W-1:0] sat_x(input logic signed [XW-1:0] v);
    if (v > WMAX_X) return W'(WMAX_X);
    if (v < WMIN_X) return W'(WMIN_X);
    return W'(v);
  endfunction

  // Clamp a working word into the 32-bit output range.
  function automatic logic signed [IO_BITS-1:0] sat_o(input logic signed [W-1:0] v);
    logic signed [XW-1:0] e;
    e = XW'(v);
    if (e > OMAX_X) return IO_BITS'(OMAX_X);
    if (e < OMIN_X) return IO_BITS'(OMIN_X);
    return IO_BITS'(e);
  endfunction

  function automatic logic signed [W-1:0] add_s(input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b);
    return sat_x(XW'(a) + XW'(b));
  endfunction

  function automatic logic signed [W-1:0] sub_s(input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b);
    return sat_x(XW'(a) - XW'(b));
  endfunction

  function automatic logic signed [2*W-1:0] mulw(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
    return (2*W)'(a) * (2*W)'(b);
  endfunction

  // Shift a full product right by sh, rounding the magnitude half away from
  // zero, then clamp to the word.
  function automatic logic signed [W-1:0] rnd(input logic signed [2*W-1:0] p,
                                              input int sh);
    logic         neg;
    logic [2*W:0] mag;
    logic [2*W:0] r;
    logic [2*W:0] lim;
    neg = p[2*W-1];
    mag = {1'b0, (neg ? (2*W)'(~p + 1'b1) : (2*W)'(p))};
    r   = (mag + ((2*W+1)'(1) << (sh-1))) >> sh;
    lim = (2*W+1)'(WMAX_X) + (2*W+1)'(neg);
    if (r > lim) r = lim;
    return neg ? W'(-r) : W'(r);
  endfunction

  // Configuration registers and the half-step factor k = qm*dt/2^(F+1).
  logic signed [IO_BITS-1:0] qm;
  logic [DT_BITS-1:0]        dt;
  logic signed [2*W-1:0]     k_prod;
  logic signed [W-1:0]       k;
  logic signed [W-1:0]       qm_w;
  logic signed [W-1:0]       dt_w;
  logic signed [W-1:0]       one_w;
  logic [1:0]                settle;

  assign qm_w  = sat_x(XW'(qm));
  assign dt_w  = sat_x(XW'({1'b0, dt}));
  assign one_w = sat_x(XW'(1) << F);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      qm     <= QM_RESET;
      dt     <= DT_RESET;
      settle <= 2'd2;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_CHARGE_OVER_MASS: qm <= cfg_data;
          REG_TIME_STEP:        dt <= cfg_data[DT_BITS-1:0];
          default: ;
        endcase
        settle <= 2'd2;
      end else if (settle != 2'd0) begin
        settle <= settle - 2'd1;
      end
    end
    k_prod <= mulw(qm_w, dt_w);
    k      <= rnd(k_prod, F + 1);
  end

  // Global advance: the whole pipe moves unless the output word is stuck.
  logic [NS-1:0] vld;
  logic          en;
  logic          in_fire;

  assign en        = !vld[NS-1] || out_ready;
  assign in_ready  = en && (settle == 2'd0);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-2:0], in_fire};
    end
  end

  // Front end: kicks, rotation vector t, first cross product, denominator.
  logic signed [W-1:0]   p0_v [3], p0_e [3], p0_b [3];
  logic signed [2*W-1:0] p1_he [3], p1_tb [3];
  logic signed [W-1:0]   p1_v [3];
  logic signed [W-1:0]   p2_h [3], p2_t [3], p2_vm [3];
  logic signed [2*W-1:0] p3_tt [3], p3_cp [6];
  logic signed [W-1:0]   p3_h [3], p3_t [3], p3_vm [3];
  logic signed [W-1:0]   p4_tt [3], p4_c [6], p4_h [3], p4_t [3], p4_vm [3];
  logic signed [W-1:0]   p5_t2a, p5_tt2;
  logic signed [W-1:0]   p5_d [3], p5_h [3], p5_t [3], p5_vm [3];
  logic signed [W-1:0]   p6_t2;
  logic signed [W-1:0]   p6_vp [3], p6_h [3], p6_t [3], p6_vm [3];
  logic signed [W-1:0]   p7_den;
  logic signed [W-1:0]   p7_vp [3], p7_h [3], p7_t [3], p7_vm [3];

  // Divider stages: one quotient bit each.
  logic [ND-1:0]       dv_n   [0:ND-1];
  logic [W-1:0]        dv_rem [0:ND-1];
  logic [W-1:0]        dv_den [0:ND-1];
  logic [ND-1:0]       dv_q   [0:ND];
  logic signed [W-1:0] dv_vm  [0:ND][3];
  logic signed [W-1:0] dv_vp  [0:ND][3];
  logic signed [W-1:0] dv_t   [0:ND][3];
  logic signed [W-1:0] dv_h   [0:ND][3];

  always_ff @(posedge clk) begin
    if (en) begin
      p0_v[0] <= sat_x(XW'(vel_x));
      p0_v[1] <= sat_x(XW'(vel_y));
      p0_v[2] <= sat_x(XW'(vel_z));
      p0_e[0] <= sat_x(XW'(efield_x));
      p0_e[1] <= sat_x(XW'(efield_y));
      p0_e[2] <= sat_x(XW'(efield_z));
      p0_b[0] <= sat_x(XW'(bfield_x));
      p0_b[1] <= sat_x(XW'(bfield_y));
      p0_b[2] <= sat_x(XW'(bfield_z));
      for (int i = 0; i < 3; i++) begin
        p1_he[i] <= mulw(k, p0_e[i]);
        p1_tb[i] <= mulw(k, p0_b[i]);
        p1_v[i]  <= p0_v[i];

        p2_h[i]  <= rnd(p1_he[i], F);
        p2_t[i]  <= rnd(p1_tb[i], F);
        p2_vm[i] <= add_s(p1_v[i], rnd(p1_he[i], F));

        // v' = v- + v- x t, products laid out as pairs per component
        p3_tt[i]       <= mulw(p2_t[i], p2_t[i]);
        p3_cp[2*i]     <= mulw(p2_vm[(i+1)%3], p2_t[(i+2)%3]);
        p3_cp[2*i+1]   <= mulw(p2_vm[(i+2)%3], p2_t[(i+1)%3]);
        p3_h[i]        <= p2_h[i];
        p3_t[i]        <= p2_t[i];
        p3_vm[i]       <= p2_vm[i];

        p4_tt[i]     <= rnd(p3_tt[i], F);
        p4_c[2*i]    <= rnd(p3_cp[2*i], F);
        p4_c[2*i+1]  <= rnd(p3_cp[2*i+1], F);
        p4_h[i]      <= p3_h[i];
        p4_t[i]      <= p3_t[i];
        p4_vm[i]     <= p3_vm[i];

        p5_d[i]  <= sub_s(p4_c[2*i], p4_c[2*i+1]);
        p5_h[i]  <= p4_h[i];
        p5_t[i]  <= p4_t[i];
        p5_vm[i] <= p4_vm[i];

        p6_vp[i] <= add_s(p5_vm[i], p5_d[i]);
        p6_h[i]  <= p5_h[i];
        p6_t[i]  <= p5_t[i];
        p6_vm[i] <= p5_vm[i];

        p7_vp[i] <= p6_vp[i];
        p7_h[i]  <= p6_h[i];
        p7_t[i]  <= p6_t[i];
        p7_vm[i] <= p6_vm[i];

        dv_vp[0][i] <= p7_vp[i];
        dv_h[0][i]  <= p7_h[i];
        dv_t[0][i]  <= p7_t[i];
        dv_vm[0][i] <= p7_vm[i];
      end
      p5_t2a <= add_s(p4_tt[0], p4_tt[1]);
      p5_tt2 <= p4_tt[2];
      p6_t2  <= add_s(p5_t2a, p5_tt2);
      p7_den <= add_s(one_w, p6_t2);
      // den is at least one, so its upper bit is always clear.
      dv_n[0]   <= NUM + ND'(p7_den[W-1:1]);
      dv_den[0] <= W'(p7_den);
      dv_rem[0] <= '0;
      dv_q[0]   <= '0;
    end
  end

  for (genvar j = 1; j <= ND; j++) begin : g_div
    logic [W-1:0] cand;
    logic         ge;

    always_comb begin
      cand = {dv_rem[j-1][W-2:0], dv_n[j-1][ND-j]};
      ge   = cand >= dv_den[j-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_q[j]  <= {dv_q[j-1][ND-2:0], ge};
        dv_vm[j] <= dv_vm[j-1];
        dv_vp[j] <= dv_vp[j-1];
        dv_t[j]  <= dv_t[j-1];
        dv_h[j]  <= dv_h[j-1];
      end
    end

    if (j < ND) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          dv_n[j]   <= dv_n[j-1];
          dv_den[j] <= dv_den[j-1];
          dv_rem[j] <= ge ? cand - dv_den[j-1] : cand;
        end
      end
    end
  end

  // Back end: s = t*f, second cross product, final kick and output clamp.
  logic signed [W-1:0]       pf_f;
  logic signed [W-1:0]       pf_vm [3], pf_vp [3], pf_t [3], pf_h [3];
  logic signed [2*W-1:0]     pm1_sp [3];
  logic signed [W-1:0]       pm1_vm [3], pm1_vp [3], pm1_h [3];
  logic signed [W-1:0]       pr1_s [3], pr1_vm [3], pr1_vp [3], pr1_h [3];
  logic signed [2*W-1:0]     pm2_cp [6];
  logic signed [W-1:0]       pm2_vm [3], pm2_h [3];
  logic signed [W-1:0]       pr2_c [6], pr2_vm [3], pr2_h [3];
  logic signed [W-1:0]       pa1_d [3], pa1_vm [3], pa1_h [3];
  logic signed [W-1:0]       pa2_vq [3], pa2_h [3];
  logic signed [IO_BITS-1:0] res [3];

  always_ff @(posedge clk) begin
    if (en) begin
      pf_f <= (dv_q[ND] > WMAX_Q) ? W'(WMAX_Q) : W'(dv_q[ND]);
      for (int i = 0; i < 3; i++) begin
        pf_vm[i] <= dv_vm[ND][i];
        pf_vp[i] <= dv_vp[ND][i];
        pf_t[i]  <= dv_t[ND][i];
        pf_h[i]  <= dv_h[ND][i];

        pm1_sp[i] <= mulw(pf_t[i], pf_f);
        pm1_vm[i] <= pf_vm[i];
        pm1_vp[i] <= pf_vp[i];
        pm1_h[i]  <= pf_h[i];

        pr1_s[i]  <= rnd(pm1_sp[i], F);
        pr1_vm[i] <= pm1_vm[i];
        pr1_vp[i] <= pm1_vp[i];
        pr1_h[i]  <= pm1_h[i];

        pm2_cp[2*i]   <= mulw(pr1_vp[(i+1)%3], pr1_s[(i+2)%3]);
        pm2_cp[2*i+1] <= mulw(pr1_vp[(i+2)%3], pr1_s[(i+1)%3]);
        pm2_vm[i]     <= pr1_vm[i];
        pm2_h[i]      <= pr1_h[i];

        pr2_c[2*i]   <= rnd(pm2_cp[2*i], F);
        pr2_c[2*i+1] <= rnd(pm2_cp[2*i+1], F);
        pr2_vm[i]    <= pm2_vm[i];
        pr2_h[i]     <= pm2_h[i];

        pa1_d[i]  <= sub_s(pr2_c[2*i], pr2_c[2*i+1]);
        pa1_vm[i] <= pr2_vm[i];
        pa1_h[i]  <= pr2_h[i];

        pa2_vq[i] <= add_s(pa1_vm[i], pa1_d[i]);
        pa2_h[i]  <= pa1_h[i];

        res[i] <= sat_o(add_s(pa2_vq[i], pa2_h[i]));
      end
    end
  end

  assign new_vel_x = res[0];
  assign new_vel_y = res[1];
  assign new_vel_z = res[2];

endmodule
